### rtl/deq_pkg.sv
// Package: types, constants and ring index helpers for the bounded deque.
`default_nettype none

package deq_pkg;

	// Ring geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [1:0] {
		FUNC_PUSH_FRONT = 2'd0,
		FUNC_PUSH_BACK  = 2'd1,
		FUNC_POP_FRONT  = 2'd2,
		FUNC_POP_BACK   = 2'd3
	} func_t;

	typedef struct packed {
		func_t                    func;
		logic signed [VAL_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic                     ok;
		logic signed [VAL_W-1:0]  front_value;
		logic signed [VAL_W-1:0]  rear_value;
		logic                     is_empty;
		logic                     is_full;
		logic [CAP_W-1:0]         count;
	} rsp_t;

	// Memory write request from the controller
	typedef struct packed {
		logic                     en;
		logic [IDX_W-1:0]         addr;
		logic [VAL_W-1:0]         data;
	} ram_wr_t;

	// Status flags of the last operation
	typedef struct packed {
		logic                     ok;
		logic                     is_empty;
		logic                     is_full;
		logic [CNT_W-1:0]         count;
	} stat_t;

	// (idx + n) mod DEPTH, for idx < DEPTH and n < DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
		input logic [IDX_W:0] n);
		logic [IDX_W:0] sum;
		sum = {1'b0, idx} + n;
		if (sum >= (IDX_W+1)'(DEPTH)) begin
			sum = sum - (IDX_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	// (idx - 1) mod DEPTH
	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] res;
		if (idx == '0) begin
			res = IDX_W'(DEPTH - 1);
		end else begin
			res = idx - IDX_W'(1);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/deq_ram.sv
// Ring storage: one write port, two read ports, registered read data.
`default_nettype none

module deq_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 4,
	parameter int WORDS  = 16
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr_a,
	input  wire logic [ADDR_W-1:0] rd_addr_b,
	output      logic [DATA_W-1:0] rd_data_a,
	output      logic [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem [WORDS];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read ports, registered read data
	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

`default_nettype wire

### rtl/deq_ctrl.sv
// Deque controller: front index, entry count, sequencing and memory requests.
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire cmd_t             cmd,
	input  wire logic [CMP_W-1:0] cap_use,
	output      logic             busy,
	output      logic             done,
	output      stat_t            stat,
	output      ram_wr_t          ram_wr,
	output      logic [IDX_W-1:0] rd_front,
	output      logic [IDX_W-1:0] rd_rear
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	stat_t             stat_q;
	logic [IDX_W-1:0]  rd_front_s1;
	logic [IDX_W-1:0]  rd_rear_s1;

	logic              accept;
	logic              full_c;
	logic              empty_c;
	logic              ok_c;
	logic [IDX_W-1:0]  front_n;
	logic [CNT_W-1:0]  count_n;
	logic [IDX_W-1:0]  rear_n;
	logic [CNT_W-1:0]  count_m1;

	// Memory is read in ST_READ; no transfer until that read is done
	assign busy   = (state_q == ST_READ);
	assign done   = (state_q == ST_RESP);
	assign accept = start && !busy;

	assign full_c  = CMP_W'(count_q) >= cap_use;
	assign empty_c = (count_q == '0);

	// Next index and count, write request for pushes
	always_comb begin
		front_n     = front_q;
		count_n     = count_q;
		ok_c        = 1'b0;
		ram_wr.en   = 1'b0;
		ram_wr.addr = front_q;
		ram_wr.data = cmd.value;
		case (cmd.func)
			FUNC_PUSH_FRONT: begin
				if (!full_c) begin
					front_n     = ring_prev(front_q);
					ram_wr.addr = front_n;
					ram_wr.en   = accept;
					count_n     = count_q + CNT_W'(1);
					ok_c        = 1'b1;
				end
			end
			FUNC_PUSH_BACK: begin
				if (!full_c) begin
					ram_wr.addr = ring_add(front_q, (IDX_W+1)'(count_q));
					ram_wr.en   = accept;
					count_n     = count_q + CNT_W'(1);
					ok_c        = 1'b1;
				end
			end
			FUNC_POP_FRONT: begin
				if (!empty_c) begin
					front_n = ring_add(front_q, (IDX_W+1)'(1));
					count_n = count_q - CNT_W'(1);
					ok_c    = 1'b1;
				end
			end
			FUNC_POP_BACK: begin
				if (!empty_c) begin
					count_n = count_q - CNT_W'(1);
					ok_c    = 1'b1;
				end
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	// Rear entry after the operation; unused when the deque ends up empty
	assign count_m1 = count_n - CNT_W'(1);
	assign rear_n   = ring_add(front_n, (IDX_W+1)'(count_m1));

	// Sequencer, index state and status outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			count_q <= '0;
			stat_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE, ST_RESP: begin
					if (accept) begin
						state_q         <= ST_READ;
						front_q         <= front_n;
						count_q         <= count_n;
						stat_q.ok       <= ok_c;
						stat_q.is_empty <= (count_n == '0);
						stat_q.is_full  <= CMP_W'(count_n) >= cap_use;
						stat_q.count    <= count_n;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Read addresses for the following cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_front_s1 <= front_n;
			rd_rear_s1  <= rear_n;
		end
	end

	assign stat     = stat_q;
	assign rd_front = rd_front_s1;
	assign rd_rear  = rd_rear_s1;

endmodule

`default_nettype wire

### rtl/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: config register, storage, result.
//
//  channel   ports                          transfer when
//  command   start, busy, cmd               start && !busy
//  result    done, rsp                      done (one cycle, no backpressure)
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// An operation: the transfer edge updates index and count and writes a pushed
// value, the next cycle reads front and rear entries from the storage (read
// data is registered), and the result shows in the cycle after.
// busy is high only in the read cycle, so a new command transfers while a
// result is shown. The result side cannot stall. Reset clears index, count,
// sequencer and capacity (to 16); the storage needs no clearing.
`default_nettype none

module bounded_double_ended_queue
	import deq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire cmd_t             cmd,
	output      logic             done,
	output      rsp_t             rsp,
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	logic [CAP_W-1:0] capacity_q;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cap_use;
	logic [CMP_W-1:0] count_ext;
	stat_t            stat;
	ram_wr_t          ram_wr;
	logic [IDX_W-1:0] rd_front;
	logic [IDX_W-1:0] rd_rear;
	logic [VAL_W-1:0] front_data;
	logic [VAL_W-1:0] rear_data;

	// Capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Usable capacity is capped at the ring depth
	assign cap_ext = CMP_W'(capacity_q);
	assign cap_use = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.cap_use  (cap_use),
		.busy     (busy),
		.done     (done),
		.stat     (stat),
		.ram_wr   (ram_wr),
		.rd_front (rd_front),
		.rd_rear  (rd_rear)
	);

	deq_ram #(
		.DATA_W (VAL_W),
		.ADDR_W (IDX_W),
		.WORDS  (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (ram_wr.en),
		.wr_addr   (ram_wr.addr),
		.wr_data   (ram_wr.data),
		.rd_addr_a (rd_front),
		.rd_addr_b (rd_rear),
		.rd_data_a (front_data),
		.rd_data_b (rear_data)
	);

	// Result; both values read as all ones when empty
	assign count_ext = CMP_W'(stat.count);

	always_comb begin
		rsp.ok          = stat.ok;
		rsp.is_empty    = stat.is_empty;
		rsp.is_full     = stat.is_full;
		rsp.count       = count_ext[CAP_W-1:0];
		rsp.front_value = stat.is_empty ? '1 : front_data;
		rsp.rear_value  = stat.is_empty ? '1 : rear_data;
	end

endmodule

`default_nettype wire

### sim/deque_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the bounded deque: mirrors the ring, predicts each result and compares it.
module deque_result_checker
	import deq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  cmd_t             cmd,
	input  logic             done,
	input  rsp_t             rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data,
	output int unsigned      pending,
	output int unsigned      errors,
	output int unsigned      checked
);

	// Mirror of the deque contents and its capacity register
	logic [VAL_W-1:0] ring [DEPTH];
	int unsigned      head;
	int unsigned      fill;
	logic [CAP_W-1:0] cap_reg;
	rsp_t             expected_rsp_q [$];
	rsp_t             want;
	rsp_t             next_rsp;

	// Apply one operation to the mirror and build the result it should produce
	task automatic apply_deque_op(input cmd_t c, output rsp_t r);
		int unsigned lim;
		lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
		r = '0;
		case (c.func)
			FUNC_PUSH_FRONT: begin
				if (fill < lim) begin
					head = (head + DEPTH - 1) % DEPTH;
					ring[head] = c.value;
					fill++;
					r.ok = 1'b1;
				end
			end
			FUNC_PUSH_BACK: begin
				if (fill < lim) begin
					ring[(head + fill) % DEPTH] = c.value;
					fill++;
					r.ok = 1'b1;
				end
			end
			FUNC_POP_FRONT: begin
				if (fill != 0) begin
					head = (head + 1) % DEPTH;
					fill--;
					r.ok = 1'b1;
				end
			end
			FUNC_POP_BACK: begin
				if (fill != 0) begin
					fill--;
					r.ok = 1'b1;
				end
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		r.is_empty = (fill == 0);
		r.is_full  = (fill >= lim);
		r.count    = CAP_W'(fill);
		// both ends read back as all ones when nothing is held
		if (fill == 0) begin
			r.front_value = '1;
			r.rear_value  = '1;
		end else begin
			r.front_value = ring[head];
			r.rear_value  = ring[(head + fill - 1) % DEPTH];
		end
	endtask

	// Compare one result against the oldest expectation
	task automatic compare_rsp(input rsp_t got, input rsp_t exp_rsp);
		if (got.ok !== exp_rsp.ok || got.front_value !== exp_rsp.front_value ||
			got.rear_value !== exp_rsp.rear_value || got.is_empty !== exp_rsp.is_empty ||
			got.is_full !== exp_rsp.is_full || got.count !== exp_rsp.count) begin
			errors++;
			if (errors <= 10) begin
				$display("ERROR result %0d exp: ok=%0b front=%0d rear=%0d empty=%0b full=%0b cnt=%0d",
					checked, exp_rsp.ok, exp_rsp.front_value, exp_rsp.rear_value,
					exp_rsp.is_empty, exp_rsp.is_full, exp_rsp.count);
				$display("       result %0d got: ok=%0b front=%0d rear=%0d empty=%0b full=%0b cnt=%0d",
					checked, got.ok, got.front_value, got.rear_value,
					got.is_empty, got.is_full, got.count);
			end
		end
	endtask

	// Watch the three channels; results are retired before a new command is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			fill = 0;
			cap_reg = CAP_RESET;
			expected_rsp_q.delete();
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("ERROR result strobe with no command outstanding");
					end
				end else begin
					want = expected_rsp_q.pop_front();
					compare_rsp(rsp, want);
					checked++;
				end
			end
			if (start && !busy) begin
				apply_deque_op(cmd, next_rsp);
				expected_rsp_q.push_back(next_rsp);
			end
			if (cfg_valid && cfg_ready) begin
				cap_reg = cfg_data;
			end
			pending <= expected_rsp_q.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the bounded deque: clock, reset, command and capacity stimulus, verdict.
module testbench;
	import deq_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 7;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_OPS = 160;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	cmd_t             cmd = '0;
	logic             cfg_valid = 1'b0;
	logic [CAP_W-1:0] cfg_data = '0;
	logic             busy;
	logic             done;
	logic             cfg_ready;
	rsp_t             rsp;

	int unsigned pending;
	int unsigned errors;
	int unsigned checked;
	int unsigned cmds_sent = 0;
	int unsigned cap_writes = 0;
	int unsigned stall_cycles = 0;
	bit          idling_on = 1'b1;

	always #HALF_PERIOD clk = ~clk;

	bounded_double_ended_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	deque_result_checker deque_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors),
		.checked   (checked)
	);

	// Watchdog: ends the run after too many cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Random gap in the command stream
	task automatic pause_sender();
		if (idling_on && $urandom_range(99) < 26) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 26);
		end
	endtask

	// One command transfer; start stays high for a following command
	task automatic issue_op(input func_t f, input logic [VAL_W-1:0] v);
		pause_sender();
		start <= 1'b1;
		cmd <= '{func: f, value: v};
		do @(posedge clk); while (busy);
		cmds_sent++;
	endtask

	// Capacity write, only once every outstanding result has come back
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	// Push data: mostly random, sometimes the signed extremes, all ones or zero
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '1;
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [CAP_W-1:0] cap_plan [8];
		logic [CAP_W-1:0] cap_now;
		int unsigned run_len;
		int unsigned n_ops;
		bit filling;
		bit push;
		func_t f;

		cap_plan = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd0, 5'd5, 5'd17, 5'd3};
		run_len = 0;
		filling = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty refusals at reset capacity, signed extremes at both ends
		issue_op(FUNC_POP_FRONT, 32'h1234_5678);
		issue_op(FUNC_POP_BACK, 32'hDEAD_BEEF);
		issue_op(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
		issue_op(FUNC_PUSH_BACK, 32'h8000_0000);
		issue_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
		issue_op(FUNC_PUSH_BACK, 32'h0000_0000);
		issue_op(FUNC_POP_BACK, 32'h0);
		issue_op(FUNC_POP_FRONT, 32'h0);

		// Capacity dropped below the count: full until pops catch up
		write_capacity(5'd1);
		issue_op(FUNC_PUSH_BACK, 32'h5555_AAAA);
		issue_op(FUNC_POP_FRONT, 32'h0);
		issue_op(FUNC_PUSH_FRONT, 32'hAAAA_5555);
		issue_op(FUNC_POP_BACK, 32'h0);
		issue_op(FUNC_POP_BACK, 32'h0);

		// Zero capacity: empty and full at once, every push refused
		write_capacity(5'd0);
		issue_op(FUNC_PUSH_FRONT, 32'h0000_0001);
		issue_op(FUNC_PUSH_BACK, 32'hFFFF_FFFE);
		issue_op(FUNC_POP_FRONT, 32'h0);

		// Random phases, each under its own capacity, with fill and drain bursts
		for (int p = 0; p < PHASES; p++) begin
			cap_now = (p < 8) ? cap_plan[p] : CAP_W'($urandom_range(31));
			write_capacity(cap_now);
			idling_on = (p != 6);
			n_ops = (cap_now == 0) ? 40 : PHASE_OPS;
			for (int i = 0; i < n_ops; i++) begin
				if (run_len == 0) begin
					filling = $urandom_range(1);
					run_len = $urandom_range(40, 4);
				end
				run_len--;
				push = filling ? ($urandom_range(99) < 75) : ($urandom_range(99) < 25);
				if (push) begin
					f = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
				end else begin
					f = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
				end
				issue_op(f, pick_value());
			end
		end

		// Drain: wait for every outstanding result, then let the clock run on quietly
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d deque operations under %0d capacity settings; %0d results compared.",
			cmds_sent, cap_writes + 1, checked);
		$display("Covered pushes and pops at both ends, full and empty refusals, capacity 0 to 31.");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
